### rtl/mcdb_pkg.sv
package mcdb_pkg;

  // Physical channel count and the number of lanes that are built.
  localparam int unsigned Channels = 8;
  localparam int unsigned Lanes    = (Channels < 8) ? Channels : 8;

  // Fixed field widths.
  localparam int unsigned ChanW  = 8;   // per-channel bit vectors
  localparam int unsigned CntW   = 8;   // mismatch counter and threshold
  localparam int unsigned IdW    = 3;   // channel_id
  localparam int unsigned ActW   = 4;   // active_channels
  localparam int unsigned ThrW   = 64;  // debounce_thresholds
  localparam int unsigned CfgIdW = 1;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdW-1:0] RegActiveChannels    = 1'b0;
  localparam logic [CfgIdW-1:0] RegDebounceThresholds = 1'b1;

  typedef enum logic [0:0] {
    FUNC_TICK  = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [ChanW-1:0] samples;
    logic [IdW-1:0]   channel_id;
  } item_t;

  // Last field in the low bits, so it matches the output tdata packing.
  typedef struct packed {
    logic [ChanW-1:0] fall_events;
    logic [ChanW-1:0] rise_events;
    logic [ChanW-1:0] change_flags;
    logic [ChanW-1:0] stable_levels;
  } result_t;

  typedef struct packed {
    logic            enable;  // tick item and lane below the active count
    logic            clear;   // clear item addressed to this lane, lane below the active count
    logic            sample;
    logic            level;
    logic            flag;
    logic [CntW-1:0] cnt;
    logic [CntW-1:0] thr;
  } lane_in_t;

  typedef struct packed {
    logic            level;
    logic            flag;
    logic [CntW-1:0] cnt;
    logic            rise;
    logic            fall;
  } lane_out_t;

endpackage

### rtl/mcdb_lane.sv
module mcdb_lane (
  input  mcdb_pkg::lane_in_t  lane_i,
  output mcdb_pkg::lane_out_t lane_o
);
  import mcdb_pkg::*;

  logic            mismatch;
  logic [CntW-1:0] cnt_inc;
  logic            hit;

  assign mismatch = lane_i.sample != lane_i.level;
  assign cnt_inc  = lane_i.cnt + CntW'(1);
  // Counter wraps, so a zero threshold needs a full wrap.
  assign hit      = mismatch && (cnt_inc == lane_i.thr);

  always_comb begin
    lane_o.level = lane_i.level;
    lane_o.flag  = lane_i.flag;
    lane_o.cnt   = lane_i.cnt;
    lane_o.rise  = 1'b0;
    lane_o.fall  = 1'b0;
    if (lane_i.enable) begin
      lane_o.level = hit ? lane_i.sample : lane_i.level;
      lane_o.flag  = lane_i.flag | hit;
      lane_o.cnt   = (mismatch && !hit) ? cnt_inc : '0;
      lane_o.rise  = hit & lane_i.sample;
      lane_o.fall  = hit & ~lane_i.sample;
    end else if (lane_i.clear) begin
      lane_o.flag = 1'b0;
    end
  end

endmodule

### rtl/mcdb_core.sv
module mcdb_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  mcdb_pkg::item_t              item_i,
  input  logic [mcdb_pkg::ActW-1:0]    active_i,
  input  logic [mcdb_pkg::ThrW-1:0]    thr_i,
  output mcdb_pkg::result_t            result_o
);
  import mcdb_pkg::*;

  logic [Lanes-1:0] level_q, level_d;
  logic [Lanes-1:0] flag_q, flag_d;
  logic [CntW-1:0]  cnt_q [Lanes];
  logic [CntW-1:0]  cnt_d [Lanes];
  logic [Lanes-1:0] rise, fall;

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    localparam logic [ActW-1:0] LaneA = ActW'(k);
    localparam logic [IdW-1:0]  LaneI = IdW'(k);
    lane_in_t  lin;
    lane_out_t lout;

    assign lin.enable = (item_i.func == FUNC_TICK) && (LaneA < active_i);
    assign lin.clear  = (item_i.func == FUNC_CLEAR) && (item_i.channel_id == LaneI) &&
                        (LaneA < active_i);
    assign lin.sample = item_i.samples[k];
    assign lin.level  = level_q[k];
    assign lin.flag   = flag_q[k];
    assign lin.cnt    = cnt_q[k];
    assign lin.thr    = thr_i[CntW*k +: CntW];

    mcdb_lane u_lane (
      .lane_i (lin),
      .lane_o (lout)
    );

    assign level_d[k] = lout.level;
    assign flag_d[k]  = lout.flag;
    assign cnt_d[k]   = lout.cnt;
    assign rise[k]    = lout.rise;
    assign fall[k]    = lout.fall;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[k] <= '0;
      end else if (step_i) begin
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      flag_q  <= '0;
    end else if (step_i) begin
      level_q <= level_d;
      flag_q  <= flag_d;
    end
  end

  // Channels beyond the built lanes read as zero.
  for (genvar k = 0; k < ChanW; k++) begin : g_out
    if (k < Lanes) begin : g_live
      assign result_o.stable_levels[k] = level_d[k];
      assign result_o.change_flags[k]  = flag_d[k];
      assign result_o.rise_events[k]   = rise[k];
      assign result_o.fall_events[k]   = fall[k];
    end else begin : g_none
      assign result_o.stable_levels[k] = 1'b0;
      assign result_o.change_flags[k]  = 1'b0;
      assign result_o.rise_events[k]   = 1'b0;
      assign result_o.fall_events[k]   = 1'b0;
    end
  end

endmodule

### rtl/multichannel_counting_debouncer_unit.sv
// Multichannel counting debouncer.
// Input stream (s_axis_*): one transaction per item. tuser carries func
// (0 = sample tick, 1 = clear the change flag of channel_id); tdata carries
// samples in bits 7..0 and channel_id in bits 10..8.
// Output stream (m_axis_*): one transaction per input item with stable
// levels, sticky change flags, and rise and fall events for that item.
// Configuration channel (cfg_*): index 0 writes active_channels (low four
// bits), index 1 writes the 64-bit packed thresholds. Always ready; write
// only while no item is in flight.
// Path: an item waits in the input register, then the lane update writes its
// result into the result register, which drives the output stream.
// Throughput: one item per cycle while the receiver keeps tready high, set by
// the lane update of the per-channel counter, level and flag registers.
// Reset: levels, counters, flags and both configuration registers clear;
// both stream stages empty.
// Stall: when the receiver holds tready low the result register holds, the
// input register fills, and then s_axis_tready drops until a slot frees.
module multichannel_counting_debouncer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mcdb_pkg::InDataW-1:0]   s_axis_tdata,  // samples[7:0], channel_id[10:8], zero
  input  logic                           s_axis_tuser,  // func
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mcdb_pkg::OutDataW-1:0]  m_axis_tdata,  // stable_levels, change_flags,
                                                        // rise_events, fall_events
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mcdb_pkg::CfgIdW-1:0]    cfg_index_i,
  input  logic [mcdb_pkg::CfgW-1:0]      cfg_data_i
);
  import mcdb_pkg::*;

  logic              in_valid_q;
  item_t             in_item_q;
  logic              out_valid_q;
  result_t           out_result_q;
  result_t           result;
  logic              step;
  logic [ActW-1:0]   active_q;
  logic [ThrW-1:0]   thr_q;

  // Advance the input register into the state and result register whenever
  // the result slot is empty or being drained this cycle.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Payload: capture only on a completed transaction.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.func       <= func_e'(s_axis_tuser);
      in_item_q.samples    <= s_axis_tdata[ChanW-1:0];
      in_item_q.channel_id <= s_axis_tdata[ChanW +: IdW];
    end
  end

  mcdb_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .active_i (active_q),
    .thr_i    (thr_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_result_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      thr_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegActiveChannels:     active_q <= cfg_data_i[ActW-1:0];
        RegDebounceThresholds: thr_q    <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/mcdb_checker.sv
module mcdb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mcdb_pkg::OutDataW-1:0] m_axis_tdata
);
  import mcdb_pkg::*;

  logic [ChanW-1:0] lvl, flg, rse, fll;

  assign lvl = m_axis_tdata[0       +: ChanW];
  assign flg = m_axis_tdata[ChanW   +: ChanW];
  assign rse = m_axis_tdata[2*ChanW +: ChanW];
  assign fll = m_axis_tdata[3*ChanW +: ChanW];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_rise_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rse & fll) == '0)
    else $error("channel rose and fell together");

  a_event_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((rse & ~lvl) == '0) && ((fll & lvl) == '0))
    else $error("event disagrees with stable level");

  a_event_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((rse | fll) & ~flg) == '0)
    else $error("event without change flag");

endmodule

bind multichannel_counting_debouncer_unit mcdb_checker u_mcdb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### verif/multichannel_counting_debouncer_unit_checker.sv
`timescale 1ns / 1ps

module multichannel_counting_debouncer_unit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [mcdb_pkg::InDataW-1:0]  in_data_i,
  input  logic                          in_func_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [mcdb_pkg::OutDataW-1:0] out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [mcdb_pkg::CfgIdW-1:0]   cfg_index_i,
  input  logic [mcdb_pkg::CfgW-1:0]     cfg_data_i,
  output int unsigned                   pending_o,
  output int unsigned                   error_count_o
);
  import mcdb_pkg::*;

  logic [ActW-1:0]  active_cfg;
  logic [ThrW-1:0]  thr_cfg;
  logic [ChanW-1:0] level_bits;
  logic [ChanW-1:0] flag_bits;
  logic [CntW-1:0]  mismatch_cnt [Lanes];

  result_t debounce_results_q [$];

  initial begin
    pending_o     = 0;
    error_count_o = 0;
  end

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("%0t: %s: expected %02h, got %02h", $time, what, want, got);
    error_count_o++;
  endtask

  // Advance the debouncer state by one item and return what it should report.
  function automatic result_t debounce_item(item_t it);
    result_t         res;
    int unsigned     lanes;
    logic [CntW-1:0] cnt;
    logic [CntW-1:0] thr;
    lanes = (active_cfg > Lanes) ? Lanes : active_cfg;
    res   = '0;
    if (it.func == FUNC_TICK) begin
      for (int k = 0; k < Lanes; k++) begin
        if (k < lanes) begin
          thr = thr_cfg[CntW*k +: CntW];
          if (it.samples[k] != level_bits[k]) begin
            cnt = mismatch_cnt[k] + 1'b1;
            if (cnt == thr) begin
              level_bits[k] = it.samples[k];
              flag_bits[k]  = 1'b1;
              if (it.samples[k]) begin
                res.rise_events[k] = 1'b1;
              end else begin
                res.fall_events[k] = 1'b1;
              end
              cnt = '0;
            end
            mismatch_cnt[k] = cnt;
          end else begin
            mismatch_cnt[k] = '0;
          end
        end
      end
    end else if (it.channel_id < lanes) begin
      flag_bits[it.channel_id] = 1'b0;
    end
    res.stable_levels = level_bits;
    res.change_flags  = flag_bits;
    return res;
  endfunction

  always @(posedge clk_i) begin
    item_t   it;
    result_t got;
    result_t want;
    if (!rst_ni) begin
      active_cfg = '0;
      thr_cfg    = '0;
      level_bits = '0;
      flag_bits  = '0;
      for (int k = 0; k < Lanes; k++) mismatch_cnt[k] = '0;
      debounce_results_q.delete();
    end else begin
      // Compare first so that a result with nothing waiting is never hidden.
      if (out_valid_i && out_ready_i) begin
        got = result_t'(out_data_i);
        if (debounce_results_q.size() == 0) begin
          report_mismatch("result with no item waiting, stable_levels", 0,
                          got.stable_levels);
        end else begin
          want = debounce_results_q.pop_front();
          if (got.stable_levels != want.stable_levels)
            report_mismatch("stable_levels", want.stable_levels, got.stable_levels);
          if (got.change_flags != want.change_flags)
            report_mismatch("change_flags", want.change_flags, got.change_flags);
          if (got.rise_events != want.rise_events)
            report_mismatch("rise_events", want.rise_events, got.rise_events);
          if (got.fall_events != want.fall_events)
            report_mismatch("fall_events", want.fall_events, got.fall_events);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegActiveChannels:     active_cfg = cfg_data_i[ActW-1:0];
          RegDebounceThresholds: thr_cfg    = cfg_data_i[ThrW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        it.func       = func_e'(in_func_i);
        it.samples    = in_data_i[ChanW-1:0];
        it.channel_id = in_data_i[ChanW +: IdW];
        debounce_results_q.push_back(debounce_item(it));
      end
    end
    pending_o <= debounce_results_q.size();
  end

endmodule

### verif/multichannel_counting_debouncer_unit_tb.sv
`timescale 1ns / 1ps

module multichannel_counting_debouncer_unit_tb;
  import mcdb_pkg::*;

  // Give up long after the slowest legal run would have finished.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseCount  = 12;
  localparam int unsigned PhaseItems  = 85;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // samples, channel_id, zero fill
  logic                s_axis_tuser  = 1'b0;  // func
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;  // stable_levels, change_flags, rise_events,
                                      // fall_events
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdW-1:0]   cfg_index_i   = '0;
  logic [CfgW-1:0]     cfg_data_i    = '0;

  int unsigned         pending;
  int unsigned         error_count;
  int unsigned         cycle_count   = 0;

  // Percent chance per cycle that the sender holds off or the receiver stalls.
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;

  multichannel_counting_debouncer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  multichannel_counting_debouncer_unit_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .in_func_i     (s_axis_tuser),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_i    (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .error_count_o (error_count)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: stall at random according to the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("multichannel_counting_debouncer_unit_tb failed");
      $finish;
    end
  end

  // Select one of the four idle patterns: none, sender only, receiver only, both.
  task automatic set_idle_mode(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  // Present one item, idling first at random, and hold it until the transaction.
  // tvalid is left high on return so back-to-back items never drop it in between.
  task automatic send_item(func_e func, logic [ChanW-1:0] samples, logic [IdW-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {{(InDataW-ChanW-IdW){1'b0}}, id, samples};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop tvalid and hold until every predicted result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Write both registers back to back while the block is idle. Junk in the
  // upper bits of the active count must be ignored by the block.
  task automatic write_config(logic [ActW-1:0] active, logic [ThrW-1:0] thresholds);
    logic [CfgW-1:0]   data [2];
    logic [CfgIdW-1:0] index [2];
    drain_results();
    index[0] = RegActiveChannels;
    data[0]  = {$urandom, $urandom};
    data[0][ActW-1:0] = active;
    index[1] = RegDebounceThresholds;
    data[1]  = thresholds;
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= index[i];
      cfg_data_i  <= data[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [ChanW-1:0] switch_pos;
    logic [ChanW-1:0] bounce;
    logic [ThrW-1:0]  thr_word;
    logic [ActW-1:0]  active;
    int unsigned      r;
    int unsigned      pick;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling.
    set_idle_mode(0);

    // Out of reset no channel is active: ticks and clears change nothing.
    send_item(FUNC_TICK, 8'hFF, 3'd0);
    send_item(FUNC_CLEAR, 8'h00, 3'd0);

    // All eight channels with threshold one: every mismatch flips at once.
    write_config(4'd8, 64'h0101_0101_0101_0101);
    send_item(FUNC_TICK, 8'hFF, 3'd7);
    send_item(FUNC_TICK, 8'h00, 3'd0);
    send_item(FUNC_TICK, 8'hFF, 3'd5);
    for (int id = 0; id < Lanes; id++) send_item(FUNC_CLEAR, 8'hFF, IdW'(id));
    send_item(FUNC_TICK, 8'h5A, 3'd2);

    // Active count above eight saturates to all lanes.
    write_config(4'd15, 64'h0202_0202_0202_0202);
    send_item(FUNC_TICK, 8'hF0, 3'd1);
    send_item(FUNC_TICK, 8'hF0, 3'd1);
    send_item(FUNC_TICK, 8'h0F, 3'd6);
    send_item(FUNC_TICK, 8'h0F, 3'd6);

    // Three channels; clears at and above the active count are ignored.
    // Channel 1 waits 255 mismatches, channels 0 and 2 wait 256 (threshold zero).
    write_config(4'd3, 64'h0000_0000_0000_FF00);
    send_item(FUNC_CLEAR, 8'hAA, 3'd3);
    send_item(FUNC_CLEAR, 8'h55, 3'd7);
    send_item(FUNC_CLEAR, 8'h00, 3'd2);
    for (int i = 0; i < 257; i++) send_item(FUNC_TICK, 8'h00, 3'd0);

    // Random part: bouncing switches that settle, plus clears and raw noise.
    switch_pos = 8'($urandom);
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       active = 4'd8;
        1:       active = 4'd15;
        2:       active = 4'd0;
        3:       active = 4'd8;
        6:       active = 4'd1;
        default: active = 4'($urandom_range(2, 15));
      endcase
      for (int k = 0; k < Lanes; k++) begin
        pick = $urandom_range(99);
        if (pick < 5) thr_word[8*k +: 8] = 8'h00;
        else if (pick < 10) thr_word[8*k +: 8] = 8'hFF;
        else thr_word[8*k +: 8] = 8'($urandom_range(1, 6));
      end
      if (ph == 3) thr_word = '1;
      write_config(active, thr_word);
      set_idle_mode(ph % 4);

      for (int i = 0; i < PhaseItems; i++) begin
        // Let the pipeline run dry once in the middle of a phase.
        if (ph == 5 && i == PhaseItems / 2) drain_results();
        r = $urandom_range(99);
        if (r < 15) begin
          send_item(FUNC_CLEAR, 8'($urandom), 3'($urandom));
        end else if (r < 25) begin
          send_item(FUNC_TICK, 8'($urandom), 3'($urandom));
        end else begin
          // Move a switch now and then; bounce around its position.
          if ($urandom_range(99) < 10) switch_pos ^= 8'd1 << $urandom_range(7);
          if ($urandom_range(99) < 3) switch_pos = 8'($urandom);
          bounce = ($urandom_range(99) < 25) ? 8'($urandom & $urandom) : 8'h00;
          send_item(FUNC_TICK, switch_pos ^ bounce, 3'($urandom));
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("multichannel_counting_debouncer_unit_tb passed");
    end else begin
      $display("multichannel_counting_debouncer_unit_tb failed");
    end
    $finish;
  end

endmodule
